// ===== rtl/prt_pkg.sv =====
`timescale 1ns / 1ps

package prt_pkg;

	localparam int TABLE_DEPTH_DEF = 256;
	localparam int MAX_SERVE_DEF   = 16;
	localparam int LOAD_SHIFT      = 20;

	localparam logic [4:0]  RESET_MAX_LOADS = 5'd4;
	localparam logic [31:0] RESET_BUDGET    = 32'd16777216;
	localparam logic [24:0] BYTES_PER_LOAD  = 25'd1048576;
	localparam logic [47:0] TOTAL_MAX       = 48'hFFFF_FFFF_FFFF;
	localparam logic [8:0]  PENDING_MAX     = 9'd511;

	typedef enum logic [1:0] {
		ACT_REQUEST = 2'd0,
		ACT_CANCEL  = 2'd1,
		ACT_STATUS  = 2'd2,
		ACT_TICK    = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		KIND_REQ_ACK    = 3'd0,
		KIND_CANCEL_ACK = 3'd1,
		KIND_STATUS     = 3'd2,
		KIND_DONE       = 3'd3,
		KIND_SUMMARY    = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		CODE_OK      = 2'd0,
		CODE_DUP     = 2'd1,
		CODE_FULL    = 2'd2,
		CODE_MISSING = 2'd3
	} code_t;

	typedef enum logic {
		CFG_MAX_LOADS = 1'b0,
		CFG_BUDGET    = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_CHECK,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] key;
		logic [7:0]  level;
		logic [1:0]  prio;
		logic [15:0] tag;
	} prt_entry_t;

	typedef struct packed {
		logic done;
		logic hit;
		logic free;
		logic best;
	} scan_flags_t;

endpackage

// ===== rtl/prt_mem.sv =====
`timescale 1ns / 1ps

module prt_mem #(
	parameter int DEPTH = prt_pkg::TABLE_DEPTH_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  prt_pkg::prt_entry_t wdata,
	input  logic                re,
	input  logic [AW-1:0]       raddr,
	output prt_pkg::prt_entry_t rdata
);
	import prt_pkg::*;

	prt_entry_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/prt_scan.sv =====
`timescale 1ns / 1ps

module prt_scan #(
	parameter int DEPTH = prt_pkg::TABLE_DEPTH_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [31:0]          key,
	input  logic [7:0]           level,
	output logic                 rd_en,
	output logic [AW-1:0]        rd_addr,
	input  prt_pkg::prt_entry_t  rd_data,
	output prt_pkg::scan_flags_t flags,
	output logic [AW-1:0]        hit_idx,
	output logic [1:0]           hit_prio,
	output logic [15:0]          hit_tag,
	output logic [AW-1:0]        free_idx,
	output logic [AW-1:0]        best_idx,
	output prt_pkg::prt_entry_t  best_entry
);
	import prt_pkg::*;

	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

	logic          busy_q;
	logic [AW-1:0] addr_q;
	logic          vld_s1;
	logic          last_s1;
	logic [AW-1:0] idx_s1;
	scan_flags_t   flags_q;
	logic [AW-1:0] hit_idx_q;
	logic [1:0]    hit_prio_q;
	logic [15:0]   hit_tag_q;
	logic [AW-1:0] free_idx_q;
	logic [AW-1:0] best_idx_q;
	prt_entry_t    best_q;
	logic          is_match;
	logic          take_best;

	assign rd_en   = busy_q;
	assign rd_addr = addr_q;

	assign is_match  = rd_data.valid && rd_data.key == key && rd_data.level == level;
	assign take_best = rd_data.valid && (!flags_q.best || rd_data.prio > best_q.prio);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			addr_q  <= '0;
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			flags_q <= '0;
		end else if (start) begin
			busy_q  <= 1'b1;
			addr_q  <= '0;
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			flags_q <= '0;
		end else begin
			flags_q.done <= vld_s1 && last_s1;
			vld_s1       <= busy_q;
			last_s1      <= busy_q && addr_q == LAST_ADDR;
			if (busy_q) begin
				addr_q <= addr_q + 1'b1;
				if (addr_q == LAST_ADDR) begin
					busy_q <= 1'b0;
				end
			end
			if (vld_s1) begin
				if (is_match && !flags_q.hit) begin
					flags_q.hit <= 1'b1;
				end
				if (!rd_data.valid && !flags_q.free) begin
					flags_q.free <= 1'b1;
				end
				if (take_best) begin
					flags_q.best <= 1'b1;
				end
			end
		end
	end

	// first hit and first free slot win; strict compare keeps the lowest slot on ties
	always_ff @(posedge clk) begin
		idx_s1 <= addr_q;
		if (vld_s1 && !start) begin
			if (is_match && !flags_q.hit) begin
				hit_idx_q  <= idx_s1;
				hit_prio_q <= rd_data.prio;
				hit_tag_q  <= rd_data.tag;
			end
			if (!rd_data.valid && !flags_q.free) begin
				free_idx_q <= idx_s1;
			end
			if (take_best) begin
				best_idx_q <= idx_s1;
				best_q     <= rd_data;
			end
		end
	end

	assign flags      = flags_q;
	assign hit_idx    = hit_idx_q;
	assign hit_prio   = hit_prio_q;
	assign hit_tag    = hit_tag_q;
	assign free_idx   = free_idx_q;
	assign best_idx   = best_idx_q;
	assign best_entry = best_q;

endmodule

// ===== rtl/priority_request_table_core.sv =====
`timescale 1ns / 1ps
// Request, cancel and status: one pass over the table; a request to a full table skips the pass.
// Tick: one pass per served entry, and one more pass if the table is found empty before a limit stops the tick.
// The pass reads the entry memory (one read port, one write port) one slot a cycle.
// The next transaction is taken as soon as the last result sits in the output register.
// After reset a clearing pass writes every slot; no transaction is taken meanwhile.

module priority_request_table_core #(
	parameter int TABLE_DEPTH = prt_pkg::TABLE_DEPTH_DEF,
	parameter int MAX_SERVE   = prt_pkg::MAX_SERVE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [31:0] chain_key,
	input  logic [7:0]  level,
	input  logic [1:0]  prio,
	input  logic [15:0] tag,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic [1:0]  code,
	output logic [31:0] done_key,
	output logic [7:0]  done_level,
	output logic [15:0] done_tag,
	output logic [8:0]  pending_count,
	output logic [31:0] completed_total,
	output logic [24:0] bytes_this_tick,
	output logic [47:0] bytes_total,
	output logic        last,
	input  logic        cfg_en,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);
	import prt_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int SW = $clog2(MAX_SERVE + 1);
	localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);

	state_t      state_q, state_d;
	logic [AW-1:0] clr_q;
	logic [4:0]  max_loads_q;
	logic [31:0] budget_q;
	logic [CW-1:0] entry_count_q;
	logic [8:0]  pending_q;
	logic [31:0] completed_q;
	logic [47:0] total_q;
	logic [24:0] tick_bytes_q;
	logic [SW-1:0] served_q;
	logic        out_valid_q;

	action_t     act_q;
	logic [31:0] key_q;
	logic [7:0]  level_q;
	logic [1:0]  prio_q;
	logic [15:0] tag_q;

	kind_t       res_kind_q;
	code_t       res_code_q;
	logic [31:0] res_key_q;
	logic [7:0]  res_level_q;
	logic [15:0] res_tag_q;
	logic        res_last_q;

	logic [2:0]  out_kind_q;
	logic [1:0]  out_code_q;
	logic [31:0] out_key_q;
	logic [7:0]  out_level_q;
	logic [15:0] out_tag_q;
	logic [8:0]  out_pending_q;
	logic [31:0] out_completed_q;
	logic [24:0] out_tick_q;
	logic [47:0] out_total_q;
	logic        out_last_q;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	prt_entry_t    mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	prt_entry_t    mem_rdata;

	logic          scan_start;
	scan_flags_t   scan_flags;
	logic [AW-1:0] hit_idx;
	logic [1:0]    hit_prio;
	logic [15:0]   hit_tag;
	logic [AW-1:0] free_idx;
	logic [AW-1:0] best_idx;
	prt_entry_t    best_entry;

	logic          can_load;
	logic          tick_go;
	logic          full;
	logic [SW+LOAD_SHIFT-1:0] served_bytes;

	prt_mem #(.DEPTH(TABLE_DEPTH)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	prt_scan #(.DEPTH(TABLE_DEPTH)) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (scan_start),
		.key        (key_q),
		.level      (level_q),
		.rd_en      (mem_re),
		.rd_addr    (mem_raddr),
		.rd_data    (mem_rdata),
		.flags      (scan_flags),
		.hit_idx    (hit_idx),
		.hit_prio   (hit_prio),
		.hit_tag    (hit_tag),
		.free_idx   (free_idx),
		.best_idx   (best_idx),
		.best_entry (best_entry)
	);

	assign can_load     = !out_valid_q || out_ready;
	assign full         = entry_count_q >= CW'(TABLE_DEPTH);
	assign served_bytes = {served_q, {LOAD_SHIFT{1'b0}}};
	assign tick_go      = (32'(served_q) < 32'(max_loads_q)) && (32'(served_q) < MAX_SERVE)
		&& (32'(served_bytes) < budget_q);
	assign in_ready     = state_q == ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		scan_start = 1'b0;
		mem_we     = 1'b0;
		mem_waddr  = clr_q;
		mem_wdata  = '0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				if (clr_q == LAST_ADDR) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					if (action_t'(action) == ACT_TICK) begin
						state_d = ST_CHECK;
					end else if (action_t'(action) == ACT_REQUEST && full) begin
						state_d = ST_RESULT;
					end else begin
						scan_start = 1'b1;
						state_d    = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (scan_flags.done) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				state_d = ST_RESULT;
				case (act_q)
					ACT_REQUEST: begin
						if (scan_flags.hit) begin
							mem_we    = prio_q > hit_prio;
							mem_waddr = hit_idx;
							mem_wdata = '{valid: 1'b1, key: key_q, level: level_q,
								prio: prio_q, tag: hit_tag};
						end else if (scan_flags.free) begin
							mem_we    = 1'b1;
							mem_waddr = free_idx;
							mem_wdata = '{valid: 1'b1, key: key_q, level: level_q,
								prio: prio_q, tag: tag_q};
						end
					end
					ACT_CANCEL: begin
						mem_we    = scan_flags.hit;
						mem_waddr = hit_idx;
					end
					ACT_TICK: begin
						mem_we    = scan_flags.best;
						mem_waddr = best_idx;
					end
					default: begin
					end
				endcase
			end
			ST_CHECK: begin
				if (tick_go) begin
					scan_start = 1'b1;
					state_d    = ST_SCAN;
				end else begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (can_load) begin
					state_d = res_last_q ? ST_IDLE : ST_CHECK;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q         <= '0;
			max_loads_q   <= RESET_MAX_LOADS;
			budget_q      <= RESET_BUDGET;
			entry_count_q <= '0;
			pending_q     <= '0;
			completed_q   <= '0;
			total_q       <= '0;
			tick_bytes_q  <= '0;
			served_q      <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_en) begin
				unique case (cfg_reg_t'(cfg_index))
					CFG_MAX_LOADS: max_loads_q <= cfg_data[4:0];
					CFG_BUDGET:    budget_q    <= cfg_data;
					default: begin
					end
				endcase
			end
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == ST_IDLE && in_valid && action_t'(action) == ACT_TICK) begin
				served_q     <= '0;
				tick_bytes_q <= '0;
			end
			if (state_q == ST_DECIDE) begin
				case (act_q)
					ACT_REQUEST: begin
						if (!scan_flags.hit && scan_flags.free) begin
							entry_count_q <= entry_count_q + 1'b1;
							if (pending_q < PENDING_MAX) begin
								pending_q <= pending_q + 1'b1;
							end
						end
					end
					ACT_CANCEL: begin
						if (scan_flags.hit) begin
							if (entry_count_q != '0) begin
								entry_count_q <= entry_count_q - 1'b1;
							end
							if (pending_q != '0) begin
								pending_q <= pending_q - 1'b1;
							end
						end
					end
					ACT_TICK: begin
						if (scan_flags.best) begin
							if (entry_count_q != '0) begin
								entry_count_q <= entry_count_q - 1'b1;
							end
							if (pending_q != '0) begin
								pending_q <= pending_q - 1'b1;
							end
							served_q     <= served_q + 1'b1;
							tick_bytes_q <= tick_bytes_q + BYTES_PER_LOAD;
							completed_q  <= completed_q + 1'b1;
							// saturate once the top bits above the load size are all set
							if (&total_q[47:LOAD_SHIFT]) begin
								total_q <= TOTAL_MAX;
							end else begin
								total_q <= total_q + 48'(BYTES_PER_LOAD);
							end
						end
					end
					default: begin
					end
				endcase
			end
			if (state_q == ST_RESULT && can_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			act_q       <= action_t'(action);
			key_q       <= chain_key;
			level_q     <= level;
			prio_q      <= prio;
			tag_q       <= tag;
			res_kind_q  <= KIND_REQ_ACK;
			res_code_q  <= CODE_FULL;
			res_key_q   <= '0;
			res_level_q <= '0;
			res_tag_q   <= '0;
			res_last_q  <= 1'b1;
		end
		if (state_q == ST_DECIDE) begin
			res_key_q   <= '0;
			res_level_q <= '0;
			res_tag_q   <= '0;
			res_last_q  <= 1'b1;
			case (act_q)
				ACT_REQUEST: begin
					res_kind_q <= KIND_REQ_ACK;
					res_code_q <= scan_flags.hit ? CODE_DUP
						: (scan_flags.free ? CODE_OK : CODE_FULL);
				end
				ACT_CANCEL: begin
					res_kind_q <= KIND_CANCEL_ACK;
					res_code_q <= scan_flags.hit ? CODE_OK : CODE_MISSING;
				end
				ACT_STATUS: begin
					res_kind_q <= KIND_STATUS;
					res_code_q <= scan_flags.hit ? CODE_OK : CODE_MISSING;
				end
				default: begin
					res_code_q <= CODE_OK;
					if (scan_flags.best) begin
						res_kind_q  <= KIND_DONE;
						res_key_q   <= best_entry.key;
						res_level_q <= best_entry.level;
						res_tag_q   <= best_entry.tag;
						res_last_q  <= 1'b0;
					end else begin
						res_kind_q <= KIND_SUMMARY;
					end
				end
			endcase
		end
		if (state_q == ST_CHECK && !tick_go) begin
			res_kind_q  <= KIND_SUMMARY;
			res_code_q  <= CODE_OK;
			res_key_q   <= '0;
			res_level_q <= '0;
			res_tag_q   <= '0;
			res_last_q  <= 1'b1;
		end
		if (state_q == ST_RESULT && can_load) begin
			out_kind_q      <= res_kind_q;
			out_code_q      <= res_code_q;
			out_key_q       <= res_key_q;
			out_level_q     <= res_level_q;
			out_tag_q       <= res_tag_q;
			out_pending_q   <= pending_q;
			out_completed_q <= completed_q;
			out_tick_q      <= tick_bytes_q;
			out_total_q     <= total_q;
			out_last_q      <= res_last_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign kind            = out_kind_q;
	assign code            = out_code_q;
	assign done_key        = out_key_q;
	assign done_level      = out_level_q;
	assign done_tag        = out_tag_q;
	assign pending_count   = out_pending_q;
	assign completed_total = out_completed_q;
	assign bytes_this_tick = out_tick_q;
	assign bytes_total     = out_total_q;
	assign last            = out_last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entry_count_q <= CW'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> !mem_we)
		else $error("memory written during a table pass");

	a_scan_done_owner: assert property (@(posedge clk) disable iff (!arst_n)
		scan_flags.done |-> state_q == ST_SCAN)
		else $error("pass finished outside the scan state");

	a_done_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESULT && can_load && res_kind_q == KIND_DONE) |-> served_q != '0)
		else $error("completion sent without a served entry");

endmodule

// ===== tb/tb_priority_request_table_core.sv =====
`timescale 1ns / 1ps

module tb_priority_request_table_core;
	import prt_pkg::*;

	localparam int DEPTH = 256;
	localparam int SERVE_CAP = 16;
	localparam longint CYCLE_LIMIT = 20000000;

	typedef struct {
		kind_t       kind;
		code_t       code;
		logic [31:0] key;
		logic [7:0]  lvl;
		logic [15:0] tg;
		logic [8:0]  pend;
		logic [31:0] comp;
		logic [24:0] tickb;
		logic [47:0] totb;
		logic        fin;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] action = '0;
	logic [31:0] chain_key = '0;
	logic [7:0] level = '0;
	logic [1:0] prio = '0;
	logic [15:0] tag = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] kind;
	logic [1:0] code;
	logic [31:0] done_key;
	logic [7:0] done_level;
	logic [15:0] done_tag;
	logic [8:0] pending_count;
	logic [31:0] completed_total;
	logic [24:0] bytes_this_tick;
	logic [47:0] bytes_total;
	logic last;
	logic cfg_en = 1'b0;
	logic cfg_index = 1'b0;
	logic [31:0] cfg_data = '0;

	// model of the table
	logic        slot_used [DEPTH];
	logic [31:0] slot_key [DEPTH];
	logic [7:0]  slot_lvl [DEPTH];
	logic [1:0]  slot_prio [DEPTH];
	logic [15:0] slot_tag [DEPTH];
	int unsigned used_slots;
	logic [8:0]  pend_stat;
	logic [31:0] comp_stat;
	logic [47:0] total_bytes;
	logic [24:0] tick_bytes;
	logic [4:0]  max_loads;
	logic [31:0] budget;

	result_t expected_results[$];
	int send_idle_pct = 6;
	int recv_idle_pct = 87;
	int failures = 0;
	longint cycles = 0;
	logic [31:0] key_pool [8];

	priority_request_table_core dut (.*);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_idle_pct);

	task automatic report(string name, longint unsigned exp_v, longint unsigned act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
			failures++;
		end
	endtask

	always @(posedge clk) begin
		result_t e;
		if (out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual kind %0d", $time, kind);
				failures++;
			end else begin
				e = expected_results.pop_front();
				report("kind", e.kind, kind);
				report("code", e.code, code);
				report("done_key", e.key, done_key);
				report("done_level", e.lvl, done_level);
				report("done_tag", e.tg, done_tag);
				report("pending_count", e.pend, pending_count);
				report("completed_total", e.comp, completed_total);
				report("bytes_this_tick", e.tickb, bytes_this_tick);
				report("bytes_total", e.totb, bytes_total);
				report("last", e.fin, last);
			end
		end
	end

	function automatic void push_result(kind_t k, code_t c, logic [31:0] key,
			logic [7:0] lvl, logic [15:0] tg);
		result_t r;
		r.kind = k; r.code = c; r.key = key; r.lvl = lvl; r.tg = tg;
		r.pend = pend_stat; r.comp = comp_stat; r.tickb = tick_bytes;
		r.totb = total_bytes; r.fin = 1'b0;
		expected_results.push_back(r);
	endfunction

	function automatic int find_slot(logic [31:0] key, logic [7:0] lvl);
		for (int i = 0; i < DEPTH; i++)
			if (slot_used[i] && slot_key[i] == key && slot_lvl[i] == lvl)
				return i;
		return -1;
	endfunction

	function automatic void predict_table(action_t act, logic [31:0] key, logic [7:0] lvl,
			logic [1:0] p, logic [15:0] tg);
		int idx;
		int best;
		int unsigned cap;
		int unsigned served;
		longint unsigned bytes;
		idx = find_slot(key, lvl);
		case (act)
			ACT_REQUEST: begin
				if (used_slots >= DEPTH) begin
					push_result(KIND_REQ_ACK, CODE_FULL, '0, '0, '0);
				end else if (idx >= 0) begin
					if (p > slot_prio[idx]) slot_prio[idx] = p;
					push_result(KIND_REQ_ACK, CODE_DUP, '0, '0, '0);
				end else begin
					idx = 0;
					while (slot_used[idx]) idx++;
					slot_used[idx] = 1'b1;
					slot_key[idx] = key; slot_lvl[idx] = lvl;
					slot_prio[idx] = p; slot_tag[idx] = tg;
					used_slots++;
					if (pend_stat < PENDING_MAX) pend_stat++;
					push_result(KIND_REQ_ACK, CODE_OK, '0, '0, '0);
				end
			end
			ACT_CANCEL: begin
				if (idx >= 0) begin
					slot_used[idx] = 1'b0;
					used_slots--;
					if (pend_stat > 0) pend_stat--;
					push_result(KIND_CANCEL_ACK, CODE_OK, '0, '0, '0);
				end else begin
					push_result(KIND_CANCEL_ACK, CODE_MISSING, '0, '0, '0);
				end
			end
			ACT_STATUS: push_result(KIND_STATUS, idx >= 0 ? CODE_OK : CODE_MISSING, '0, '0, '0);
			default: begin
				cap = (max_loads > SERVE_CAP) ? SERVE_CAP : max_loads;
				served = 0;
				bytes = 0;
				tick_bytes = '0;
				while (served < cap && bytes < budget) begin
					best = -1;
					for (int i = 0; i < DEPTH; i++)
						if (slot_used[i] && (best < 0 || slot_prio[i] > slot_prio[best]))
							best = i;
					if (best < 0) break;
					slot_used[best] = 1'b0;
					used_slots--;
					served++;
					bytes += BYTES_PER_LOAD;
					tick_bytes = bytes[24:0];
					if (TOTAL_MAX - total_bytes < BYTES_PER_LOAD) total_bytes = TOTAL_MAX;
					else total_bytes += BYTES_PER_LOAD;
					comp_stat++;
					if (pend_stat > 0) pend_stat--;
					push_result(KIND_DONE, CODE_OK, slot_key[best], slot_lvl[best],
						slot_tag[best]);
				end
				push_result(KIND_SUMMARY, CODE_OK, '0, '0, '0);
			end
		endcase
		expected_results[$].fin = 1'b1;
	endfunction

	task automatic send_item(action_t act, logic [31:0] key, logic [7:0] lvl,
			logic [1:0] p, logic [15:0] tg);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act; chain_key <= key; level <= lvl; prio <= p; tag <= tg;
		do @(posedge clk); while (!in_ready);
		predict_table(act, key, lvl, p, tg);
	endtask

	// hold the sender until the block has delivered everything
	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_cfg(cfg_reg_t idx, logic [31:0] val);
		drain();
		cfg_en <= 1'b1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		cfg_en <= 1'b0;
		if (idx == CFG_MAX_LOADS) max_loads = val[4:0];
		else budget = val;
	endtask

	task automatic test_directed;
		send_item(ACT_REQUEST, 32'hFFFF_FFFF, 8'hFF, 2'd3, 16'hFFFF);
		send_item(ACT_REQUEST, 32'h0, 8'h0, 2'd0, 16'h0);
		send_item(ACT_REQUEST, 32'h0, 8'h0, 2'd2, 16'h1234);
		send_item(ACT_REQUEST, 32'hFFFF_FFFF, 8'hFF, 2'd0, 16'h5555);
		send_item(ACT_REQUEST, 32'hA5A5_5A5A, 8'h80, 2'd2, 16'hAAAA);
		send_item(ACT_STATUS, 32'h0, 8'h0, 2'd0, 16'h0);
		send_item(ACT_STATUS, 32'h0, 8'h1, 2'd0, 16'h0);
		send_item(ACT_CANCEL, 32'hA5A5_5A5A, 8'h80, 2'd0, 16'h0);
		send_item(ACT_CANCEL, 32'hA5A5_5A5A, 8'h80, 2'd0, 16'h0);
		send_item(ACT_TICK, '0, '0, '0, '0);
		send_item(ACT_REQUEST, 32'h1, 8'h1, 2'd1, 16'h0F0F);
		send_item(ACT_REQUEST, 32'h2, 8'h1, 2'd1, 16'hF0F0);
		write_cfg(CFG_MAX_LOADS, 32'd0);
		send_item(ACT_TICK, '0, '0, '0, '0);
		write_cfg(CFG_MAX_LOADS, 32'd31);
		write_cfg(CFG_BUDGET, 32'd0);
		send_item(ACT_TICK, '0, '0, '0, '0);
		write_cfg(CFG_BUDGET, 32'd1);
		send_item(ACT_TICK, '0, '0, '0, '0);
		write_cfg(CFG_BUDGET, 32'hFFFF_FFFF);
		send_item(ACT_TICK, '0, '0, '0, '0);
	endtask

	task automatic test_table_full;
		for (int i = 0; i < DEPTH; i++)
			send_item(ACT_REQUEST, $urandom, 8'(i), 2'($urandom_range(3)), 16'($urandom));
		// duplicates are refused as well once full
		send_item(ACT_REQUEST, slot_key[7], slot_lvl[7], 2'd3, 16'h0);
		send_item(ACT_REQUEST, 32'hDEAD_0000, 8'h5, 2'd1, 16'h1);
		send_item(ACT_CANCEL, slot_key[100], slot_lvl[100], 2'd0, 16'h0);
		send_item(ACT_REQUEST, slot_key[7], slot_lvl[7], 2'd3, 16'h0);
		send_item(ACT_REQUEST, 32'hDEAD_0000, 8'h5, 2'd1, 16'h1);
		write_cfg(CFG_MAX_LOADS, 32'd16);
		while (used_slots != 0) send_item(ACT_TICK, '0, '0, '0, '0);
	endtask

	task automatic test_random(int count);
		int r;
		logic [31:0] key;
		logic [7:0] lvl;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(99) < 10) begin
				key = $urandom; lvl = $urandom;
			end else begin
				key = key_pool[$urandom_range(7)]; lvl = 8'($urandom_range(3));
			end
			r = $urandom_range(99);
			if (r < 45) send_item(ACT_REQUEST, key, lvl, 2'($urandom), 16'($urandom));
			else if (r < 60) send_item(ACT_CANCEL, key, lvl, 2'($urandom), 16'($urandom));
			else if (r < 80) send_item(ACT_STATUS, key, lvl, 2'($urandom), 16'($urandom));
			else send_item(ACT_TICK, key, lvl, 2'($urandom), 16'($urandom));
		end
	endtask

	initial begin
		for (int i = 0; i < DEPTH; i++) slot_used[i] = 1'b0;
		used_slots = 0; pend_stat = '0; comp_stat = '0;
		total_bytes = '0; tick_bytes = '0;
		max_loads = RESET_MAX_LOADS; budget = RESET_BUDGET;
		for (int i = 0; i < 8; i++) key_pool[i] = $urandom;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_table_full();
		write_cfg(CFG_MAX_LOADS, 32'd3);
		write_cfg(CFG_BUDGET, 32'd3145728);
		test_random(50);
		send_idle_pct = 87;
		recv_idle_pct = 6;
		write_cfg(CFG_MAX_LOADS, 32'd20);
		write_cfg(CFG_BUDGET, RESET_BUDGET);
		test_random(50);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_cfg(CFG_MAX_LOADS, 32'($urandom_range(1, 16)));
		write_cfg(CFG_BUDGET, 32'($urandom_range(1, 20)) << 20);
		test_random(50);

		drain();
		repeat (300) @(posedge clk);
		if (failures == 0 && expected_results.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ===== priority_request_table_core.f =====
rtl/prt_pkg.sv
rtl/prt_mem.sv
rtl/prt_scan.sv
rtl/priority_request_table_core.sv
tb/tb_priority_request_table_core.sv
